/* sv/msw_pkg.sv */
// Shared types and constants for the 1-D flat-kernel window average core.
// Depends on nothing; imported by the controller, datapath and top level.
`default_nettype none

package msw_pkg;

  // Fixed-point format of the samples and the threshold
  localparam int unsigned SampleW = 32;
  localparam int unsigned ThW     = 31;
  localparam int unsigned FracBits = 16;
  localparam logic [ThW-1:0] ThReset = ThW'(64'd1 << FracBits);

  // Input beat
  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last_sample;
  } item_t;

  // Result beat
  typedef struct packed {
    logic signed [SampleW-1:0] mean_value;
    logic                      last_result;
    logic                      overflow;
  } result_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CENTER_RD,
    ST_CENTER_LD,
    ST_RIGHT,
    ST_RIGHT_CHK,
    ST_LEFT,
    ST_LEFT_CHK,
    ST_DIVIDE
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic center_rd;
    logic center_ld;
    logic right_rd;
    logic right_acc;
    logic left_init;
    logic left_rd;
    logic left_acc;
    logic div_start;
    logic emit;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic right_more;
    logic left_more;
    logic hit_right;
    logic hit_left;
    logic div_done;
    logic last_center;
  } status_t;

endpackage

`default_nettype wire

/* sv/mean_shift_1d_window_average_core.sv */
// Top level of the 1-D flat-kernel window average core.
// Depends on msw_pkg, msw_ctrl and msw_datapath.
//
// Usage:
//   Input: drive item_i and raise start; a beat is taken at a rising edge
//   with start high and busy low. Samples load at one per cycle into the
//   point memory (MAX_POINTS entries); further samples are dropped and the
//   overflow flag of that set is raised. A beat with last_sample closes
//   the set, and busy rises until all results are out.
//   Output: one result beat per stored point, in order, each shown for one
//   cycle with result_strobe_o high. The receiver cannot stall; it must
//   take every beat. last_result marks the final point of the set.
//   Steps per point: read and then load the center, read and then check
//   each neighbor examined by each walk, close a walk that reaches the end
//   of the set, then run a restoring divider; the pace is set by the single
//   memory read port and the one-bit-per-cycle divider.
//   Configuration: threshold_we_i writes threshold_i; the user must write
//   it only while idle, as the block itself does not enforce this.
//   Reset: empties the set, clears the flags, threshold = 1.0 in unsigned Q15.16.
`default_nettype none

module mean_shift_1d_window_average_core #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  input  msw_pkg::item_t          item_i,
  output logic                    busy,
  output msw_pkg::result_t        result_o,
  output logic                    result_strobe_o,
  input  logic                    threshold_we_i,
  input  logic [msw_pkg::ThW-1:0] threshold_i
);
  import msw_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer
  msw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .last_i   (item_i.last_sample),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  // Storage and arithmetic
  msw_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sample_i        (item_i.sample),
    .th_we_i         (threshold_we_i),
    .th_i            (threshold_i),
    .status_o        (status),
    .result_o        (result_o),
    .result_strobe_o (result_strobe_o)
  );

endmodule

`default_nettype wire

/* sv/msw_ctrl.sv */
// Controller state machine: sequences load, window walks, divide and emit.
// Depends on msw_pkg for the state enum and the command/status structs.
`default_nettype none

module msw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             last_i,
  input  msw_pkg::status_t status_i,
  output msw_pkg::cmd_t    cmd_o,
  output logic             busy
);
  import msw_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = start && (state_q == ST_IDLE);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && last_i) state_d = ST_CENTER_RD;
      end
      ST_CENTER_RD: state_d = ST_CENTER_LD;
      ST_CENTER_LD: state_d = ST_RIGHT;
      ST_RIGHT: begin
        state_d = status_i.right_more ? ST_RIGHT_CHK : ST_LEFT;
      end
      ST_RIGHT_CHK: begin
        state_d = status_i.hit_right ? ST_RIGHT : ST_LEFT;
      end
      ST_LEFT: begin
        state_d = status_i.left_more ? ST_LEFT_CHK : ST_DIVIDE;
      end
      ST_LEFT_CHK: begin
        state_d = status_i.hit_left ? ST_LEFT : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (status_i.div_done) begin
          state_d = status_i.last_center ? ST_IDLE : ST_CENTER_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = accept;
      end
      ST_CENTER_RD: cmd_o.center_rd = 1'b1;
      ST_CENTER_LD: cmd_o.center_ld = 1'b1;
      ST_RIGHT: begin
        cmd_o.right_rd  = status_i.right_more;
        cmd_o.left_init = !status_i.right_more;
      end
      ST_RIGHT_CHK: begin
        cmd_o.right_acc = status_i.hit_right;
        cmd_o.left_init = !status_i.hit_right;
      end
      ST_LEFT: begin
        cmd_o.left_rd   = status_i.left_more;
        cmd_o.div_start = !status_i.left_more;
      end
      ST_LEFT_CHK: begin
        cmd_o.left_acc  = status_i.hit_left;
        cmd_o.div_start = !status_i.hit_left;
      end
      ST_DIVIDE: cmd_o.emit = status_i.div_done;
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

/* sv/msw_datapath.sv */
// Datapath: point memory, window walk registers, serial divider, result beat.
// Depends on msw_pkg; driven by msw_ctrl through cmd_t and reports status_t.
`default_nettype none

module msw_datapath #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  msw_pkg::cmd_t                  cmd_i,
  input  logic [msw_pkg::SampleW-1:0]    sample_i,
  input  logic                           th_we_i,
  input  logic [msw_pkg::ThW-1:0]        th_i,
  output msw_pkg::status_t               status_o,
  output msw_pkg::result_t               result_o,
  output logic                           result_strobe_o
);
  import msw_pkg::*;

  localparam int unsigned IdxW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned SumW  = SampleW + $clog2(MAX_POINTS) + 1;
  localparam int unsigned DivCW = $clog2(SumW + 1);
  localparam int unsigned DiffW = SampleW + 1;

  // Point memory
  logic [SampleW-1:0] mem_q [MAX_POINTS];
  logic [SampleW-1:0] rdata_q;
  logic [IdxW-1:0]    raddr;

  // Set state and walk registers
  logic [CntW-1:0]    count_q;
  logic               dropped_q;
  logic [ThW-1:0]     th_q;
  logic [IdxW-1:0]    c_q;
  logic [IdxW-1:0]    w_q;
  logic [SampleW-1:0] xc_q;
  logic [SumW-1:0]    sum_q;
  logic [CntW-1:0]    size_q;

  // Divider registers
  logic [DivCW-1:0]   div_cnt_q;
  logic [SumW-1:0]    quo_q;
  logic [CntW-1:0]    rem_q;
  logic               neg_q;

  logic               room;
  logic [CntW-1:0]    w_ext;
  logic [CntW-1:0]    c_ext;
  logic [DiffW-1:0]   rd_ext;
  logic [DiffW-1:0]   xc_ext;
  logic [DiffW-1:0]   th_ext;
  logic [DiffW-1:0]   diff_r;
  logic [DiffW-1:0]   diff_l;
  logic [SumW-1:0]    rd_sum_ext;
  logic [SumW-1:0]    sum_mag;
  logic [CntW:0]      rem_sh;
  logic               rem_ge;
  logic [SampleW-1:0] quo_lo;

  assign room   = count_q < CntW'(MAX_POINTS);
  assign w_ext  = CntW'(w_q);
  assign c_ext  = CntW'(c_q);
  assign rd_ext = {rdata_q[SampleW-1], rdata_q};
  assign xc_ext = {xc_q[SampleW-1], xc_q};
  assign th_ext = DiffW'(th_q);
  assign diff_r = rd_ext - xc_ext;
  assign diff_l = xc_ext - rd_ext;
  assign rd_sum_ext = {{(SumW-SampleW){rdata_q[SampleW-1]}}, rdata_q};
  assign sum_mag = sum_q[SumW-1] ? (~sum_q + 1'b1) : sum_q;

  // Status toward the controller
  always_comb begin
    status_o.right_more  = (w_ext + 1'b1) < count_q;
    status_o.left_more   = (w_q != '0);
    status_o.hit_right   = $signed(diff_r) < $signed(th_ext);
    status_o.hit_left    = $signed(diff_l) < $signed(th_ext);
    status_o.div_done    = (div_cnt_q == '0);
    status_o.last_center = (c_ext + 1'b1) == count_q;
  end

  // Select the read address for the current step
  always_comb begin
    raddr = '0;
    if (cmd_i.center_rd) begin
      raddr = c_q;
    end else if (cmd_i.right_rd) begin
      raddr = w_q + 1'b1;
    end else if (cmd_i.left_rd) begin
      raddr = w_q - 1'b1;
    end
  end

  // Write an incoming beat, read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && room) begin
      mem_q[count_q[IdxW-1:0]] <= sample_i;
    end
    rdata_q <= mem_q[raddr];
  end

  // Threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      th_q <= ThReset;
    end else if (th_we_i) begin
      th_q <= th_i;
    end
  end

  // Fill count, drop flag and center index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
      c_q       <= '0;
    end else begin
      if (cmd_i.load) begin
        if (room) begin
          count_q <= count_q + 1'b1;
        end else begin
          dropped_q <= 1'b1;
        end
      end
      if (cmd_i.emit) begin
        if (status_o.last_center) begin
          c_q       <= '0;
          count_q   <= '0;
          dropped_q <= 1'b0;
        end else begin
          c_q <= c_q + 1'b1;
        end
      end
    end
  end

  // Window walk: center load, right and left accumulation
  always_ff @(posedge clk_i) begin
    if (cmd_i.center_ld) begin
      xc_q   <= rdata_q;
      sum_q  <= rd_sum_ext;
      size_q <= CntW'(1);
      w_q    <= c_q;
    end else if (cmd_i.right_acc) begin
      sum_q  <= sum_q + rd_sum_ext;
      size_q <= size_q + 1'b1;
      w_q    <= w_q + 1'b1;
    end else if (cmd_i.left_init) begin
      w_q    <= c_q;
    end else if (cmd_i.left_acc) begin
      sum_q  <= sum_q + rd_sum_ext;
      size_q <= size_q + 1'b1;
      w_q    <= w_q - 1'b1;
    end
  end

  // Restoring divider step: one quotient bit per cycle
  assign rem_sh = {rem_q, quo_q[SumW-1]};
  assign rem_ge = rem_sh >= {1'b0, size_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      div_cnt_q <= DivCW'(SumW);
    end else if (div_cnt_q != '0) begin
      div_cnt_q <= div_cnt_q - 1'b1;
    end
  end

  // Keep the remainder below the window size, so it fits the count width
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      quo_q <= sum_mag;
      rem_q <= '0;
      neg_q <= sum_q[SumW-1];
    end else if (div_cnt_q != '0) begin
      quo_q <= {quo_q[SumW-2:0], rem_ge};
      rem_q <= CntW'(rem_ge ? (rem_sh - {1'b0, size_q}) : rem_sh);
    end
  end

  // Result beat: restore the sign; the strobe is high for one cycle
  assign quo_lo = quo_q[SampleW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_strobe_o <= 1'b0;
    end else begin
      result_strobe_o <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      result_o.mean_value  <= neg_q ? (~quo_lo + 1'b1) : quo_lo;
      result_o.last_result <= status_o.last_center;
      result_o.overflow    <= dropped_q;
    end
  end

endmodule

`default_nettype wire

/* tb/sv/tb_mean_shift_1d_window_average_core.sv */
// Self-checking testbench for the 1-D flat-kernel window average core.
// Depends on msw_pkg and mean_shift_1d_window_average_core; predicts every
// window mean from its own copy of the point set and checks each result beat.
`default_nettype none

module tb_mean_shift_1d_window_average_core;
  import msw_pkg::*;

  localparam int unsigned MaxPoints = 64;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned QuietLimit = 5000;
  localparam int unsigned RandomItems = 32;
  localparam logic signed [SampleW-1:0] MinSample = 32'sh8000_0000;
  localparam logic signed [SampleW-1:0] MaxSample = 32'sh7fff_ffff;
  localparam longint SampleLo = -64'sd2147483648;
  localparam longint SampleHi = 64'sd2147483647;
  localparam logic [ThW-1:0] ThMax = {ThW{1'b1}};

  typedef logic signed [SampleW-1:0] point_q_t[$];

  logic           clk_i;
  logic           rst_ni;
  logic           start;
  item_t          item_i;
  logic           busy;
  result_t        result_o;
  logic           result_strobe_o;
  logic           threshold_we_i;
  logic [ThW-1:0] threshold_i;

  // Predictor state: the open point set and the current window half width
  logic signed [SampleW-1:0] loaded_points[MaxPoints];
  int unsigned               loaded_count = 0;
  bit                        points_dropped = 1'b0;
  logic [ThW-1:0]            window_thr = ThReset;
  result_t                   expected_means[$];

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;

  mean_shift_1d_window_average_core #(
    .MAX_POINTS(MaxPoints)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .item_i         (item_i),
    .busy           (busy),
    .result_o       (result_o),
    .result_strobe_o(result_strobe_o),
    .threshold_we_i (threshold_we_i),
    .threshold_i    (threshold_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Compute the window mean of every stored point and queue the result beats
  function automatic void emit_window_means();
    longint      centre;
    longint      total;
    longint      mean;
    int unsigned r;
    int unsigned l;
    result_t     res;
    for (int unsigned c = 0; c < loaded_count; c++) begin
      centre = longint'(loaded_points[c]);
      total = centre;
      r = c;
      l = c;
      // walk right while the neighbor sits less than the threshold above
      while (r + 1 < loaded_count &&
             longint'(loaded_points[r + 1]) - centre < longint'(window_thr)) begin
        r++;
        total += longint'(loaded_points[r]);
      end
      // walk left while the neighbor sits less than the threshold below
      while (l > 0 && centre - longint'(loaded_points[l - 1]) < longint'(window_thr)) begin
        l--;
        total += longint'(loaded_points[l]);
      end
      mean = total / longint'(r - l + 1);
      res.mean_value = mean[SampleW-1:0];
      res.last_result = (c + 1 == loaded_count);
      res.overflow = points_dropped;
      expected_means.push_back(res);
    end
    loaded_count = 0;
    points_dropped = 1'b0;
  endfunction

  // Track threshold writes and accepted sample beats
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      loaded_count = 0;
      points_dropped = 1'b0;
      window_thr = ThReset;
    end else begin
      if (threshold_we_i) begin
        window_thr = threshold_i;
      end
      if (start && !busy) begin
        if (loaded_count < MaxPoints) begin
          loaded_points[loaded_count] = item_i.sample;
          loaded_count++;
        end else begin
          points_dropped = 1'b1;
        end
        if (item_i.last_sample) begin
          emit_window_means();
        end
      end
    end
  end

  // Compare each result beat with the oldest expected mean
  always @(posedge clk_i) begin : check_result
    result_t want;
    if (rst_ni && result_strobe_o) begin
      if (expected_means.size() == 0) begin
        $error("unexpected result beat: mean_value %0d", result_o.mean_value);
        mismatch_count++;
      end else begin
        want = expected_means.pop_front();
        if (result_o.mean_value !== want.mean_value) begin
          $error("mean_value: expected %0d, got %0d", want.mean_value, result_o.mean_value);
          mismatch_count++;
        end
        if (result_o.last_result !== want.last_result) begin
          $error("last_result: expected %0b, got %0b", want.last_result,
                 result_o.last_result);
          mismatch_count++;
        end
        if (result_o.overflow !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, result_o.overflow);
          mismatch_count++;
        end
      end
    end
  end

  // Count cycles in which no beat moves in either direction
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_strobe_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("FAIL");
    $finish;
  end

  function automatic longint unsigned rand_below(longint unsigned m);
    return {$urandom, $urandom} % m;
  endfunction

  // Send one sample beat; open an idle gap when the current burst runs out
  task automatic send_beat(input logic signed [SampleW-1:0] s, input logic last);
    if (burst_left == 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk_i);
    item_i <= '{sample: s, last_sample: last};
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    burst_left--;
    items_sent++;
  endtask

  // Send a whole point set, the final beat flagged last
  task automatic send_points(input point_q_t pts);
    foreach (pts[i]) begin
      send_beat(pts[i], i == pts.size() - 1);
    end
  endtask

  // Hold off until every expected result is out and the core is idle
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    burst_left = 0;
    while (expected_means.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [ThW-1:0] value);
    drain();
    @(negedge clk_i);
    threshold_we_i <= 1'b1;
    threshold_i <= value;
    @(negedge clk_i);
    threshold_we_i <= 1'b0;
  endtask

  // Sorted set with random steps of at most step_max
  task automatic send_sorted_set(input int unsigned n, input longint unsigned step_max);
    point_q_t pts;
    longint   v;
    longint   top;
    top = SampleHi - longint'(step_max * n);
    if (top < SampleLo) top = SampleLo;
    v = SampleLo + longint'(rand_below(longint'(top - SampleLo) + 1));
    repeat (n) begin
      pts.push_back(v[SampleW-1:0]);
      v += longint'(rand_below(step_max + 1));
      if (v > SampleHi) v = SampleHi;
    end
    send_points(pts);
  endtask

  task automatic send_noise_set(input int unsigned n);
    point_q_t pts;
    repeat (n) pts.push_back($urandom);
    send_points(pts);
  endtask

  function automatic logic [ThW-1:0] pick_threshold();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return ThMax;
      2: return ThReset;
      3: return ThW'($urandom);
      default: return ThW'($urandom_range(1, 1 << 20));
    endcase
  endfunction

  // Default threshold: single point, extremes, exact boundary, negative means
  task automatic test_default_window();
    send_points('{32'sd0});
    send_points('{MinSample, MaxSample});
    send_points('{-32'sd3, -32'sd2});
    send_points('{32'sd0, 32'sd65536, 32'sd131072});
    send_points('{32'sd0, 32'sd65535});
    send_points('{32'sd100000, 32'sd0, 32'sd200000});
  endtask

  // Widest and zero threshold, with unsorted points
  task automatic test_threshold_extremes();
    write_threshold(ThMax);
    send_points('{MinSample, -32'sd1, 32'sd0, MaxSample});
    write_threshold('0);
    send_points('{32'sd5, 32'sd5, 32'sd3});
    send_points('{MaxSample, MinSample});
  endtask

  // Fill the store, overrun it and close the set on a dropped sample
  task automatic test_store_full();
    write_threshold(ThW'($urandom_range(1, 1 << 18)));
    send_sorted_set(MaxPoints + $urandom_range(1, 4), 2 * longint'(window_thr) + 1);
  endtask

  // Mostly sorted sets of random content, some noise, with changing thresholds
  task automatic test_random_sets();
    int unsigned     first;
    int unsigned     n;
    longint unsigned step_max;
    first = items_sent;
    while (items_sent - first < RandomItems) begin
      if ($urandom_range(0, 2) == 0) write_threshold(pick_threshold());
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      case ($urandom_range(0, 2))
        0: step_max = longint'(window_thr) / 4 + 1;
        1: step_max = longint'(window_thr) + 1;
        default: step_max = 2 * longint'(window_thr) + 1;
      endcase
      if ($urandom_range(0, 4) == 0) begin
        send_noise_set(n);
      end else begin
        send_sorted_set(n, step_max);
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    threshold_we_i = 1'b0;
    threshold_i = ThReset;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_default_window();
    test_threshold_extremes();
    test_store_full();
    test_random_sets();

    drain();
    repeat (4 * SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
